// ===== rtl/pnce_pkg.sv =====
`timescale 1ns / 1ps

package pnce_pkg;

    localparam int IDX_W     = 18;   // linear cell index
    localparam int CELL_W    = 7;    // cell count register
    localparam int COORD_W   = 6;    // one coordinate, below 64
    localparam int S0_W      = 13;   // n1 * n2, up to 4096
    localparam int P1_W      = 12;   // dimension 1 contribution, below 4096
    localparam int TOT_W     = 19;   // n0 * n1 * n2, up to 262144
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 2;

    localparam logic [CELL_W-1:0] MAX_CELLS = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DIM0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DIM1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DIM2 = 2'd2;

    // offset digit of one dimension
    typedef logic [1:0] t_digit;
    localparam t_digit OFF_MINUS = 2'd0;
    localparam t_digit OFF_ZERO  = 2'd1;
    localparam t_digit OFF_PLUS  = 2'd2;

    typedef struct packed {
        logic [CELL_W-1:0] n0;
        logic [CELL_W-1:0] n1;
        logic [CELL_W-1:0] n2;
    } t_counts;

    // one classified request handed from front to back
    typedef struct packed {
        logic               err;
        logic [IDX_W-1:0]   a0_m;
        logic [IDX_W-1:0]   a0_z;
        logic [IDX_W-1:0]   a0_p;
        logic [P1_W-1:0]    a1_m;
        logic [P1_W-1:0]    a1_z;
        logic [P1_W-1:0]    a1_p;
        logic [COORD_W-1:0] a2_m;
        logic [COORD_W-1:0] a2_z;
        logic [COORD_W-1:0] a2_p;
        logic [2:0]         one;    // dimension has a single cell
        logic [2:0]         two;    // dimension has two cells
        t_digit             last0;
        t_digit             last1;
        t_digit             last2;
    } t_entry;

    function automatic logic [CELL_W-1:0] f_eff_count(input logic [CELL_W-1:0] raw);
        logic [CELL_W-1:0] n;
        n = raw;
        if (raw == '0) begin
            n = CELL_W'(1);
        end else if (raw > MAX_CELLS) begin
            n = MAX_CELLS;
        end
        return n;
    endfunction

    // first offset digit that reaches a given wrapped coordinate
    function automatic logic f_canon(input logic one, input logic two, input t_digit dig);
        logic ok;
        ok = 1'b1;
        if (one) begin
            ok = (dig == OFF_MINUS);
        end else if (two) begin
            ok = (dig != OFF_PLUS);
        end
        return ok;
    endfunction

endpackage

// ===== rtl/periodic_neighbor_cell_enumerator_core.sv =====
`timescale 1ns / 1ps

// Periodic neighbor-cell enumerator for a 3-D linked-cell grid. Each request
// carries a linear cell index (dimension 2 varies fastest); the block returns
// every distinct periodic neighbor cell of it, in offset order with the
// dimension 0 offset varying fastest, and flags the final one with o_last.
// The cell itself is never returned, and a grid of one cell returns nothing.
// An index at or above the cell count gives a single result with
// o_index_error and o_last set and index 0. Cell counts come from three
// registers; 0 reads as 1 and anything above 64 as 64. Write them only while
// the block is idle. The front works through its states in order: two
// multiplies for the grid size and range check, two 18-bit divisions at two
// quotient bits per cycle to get the coordinates, a multiply step for the
// strides, one push; an out-of-range request skips the divisions. The back
// walks one offset per cycle while its result is not held, and stops at the
// final neighbor or the last offset; an out-of-range request gives one result.
// A two-entry queue between them lets the front work on the next request while
// the back is still emitting. A held result stalls the back first; the front
// raises o_in_stall whenever it is busy with a request, and waits in its push
// state while both queue entries are taken.

module periodic_neighbor_cell_enumerator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [pnce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pnce_pkg::CELL_W-1:0]      i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [pnce_pkg::IDX_W-1:0]       i_cell_index,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [pnce_pkg::IDX_W-1:0]       o_neighbor_index,
    output logic                             o_last,
    output logic                             o_index_error
);

    logic [pnce_pkg::CELL_W-1:0]  r_cells0, r_cells1, r_cells2;
    pnce_pkg::t_counts            w_counts;

    logic                         w_push;
    pnce_pkg::t_entry             w_push_entry;
    logic                         w_q_full;
    logic                         w_q_valid;
    pnce_pkg::t_entry             w_q_data;
    logic                         w_q_pop;

    // cell count registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells0 <= pnce_pkg::CELL_W'(1);
            r_cells1 <= pnce_pkg::CELL_W'(1);
            r_cells2 <= pnce_pkg::CELL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pnce_pkg::CFG_CELLS_DIM0: r_cells0 <= i_cfg_data;
                pnce_pkg::CFG_CELLS_DIM1: r_cells1 <= i_cfg_data;
                pnce_pkg::CFG_CELLS_DIM2: r_cells2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp counts into 1..64 once, for the front
    assign w_counts.n0 = pnce_pkg::f_eff_count(r_cells0);
    assign w_counts.n1 = pnce_pkg::f_eff_count(r_cells1);
    assign w_counts.n2 = pnce_pkg::f_eff_count(r_cells2);

    // front: range check, coordinate split and wrapped strides
    pnce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_counts     (w_counts),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cell_index (i_cell_index),
        .o_push       (w_push),
        .o_entry      (w_push_entry),
        .i_full       (w_q_full)
    );

    // decouples classification from the neighbor walk
    pnce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    // back: one offset per cycle while the output is not held, into the output register
    pnce_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_data         (w_q_data),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_neighbor_index (o_neighbor_index),
        .o_last           (o_last),
        .o_index_error    (o_index_error)
    );

endmodule

// ===== rtl/pnce_front.sv =====
`timescale 1ns / 1ps

module pnce_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pnce_pkg::t_counts             i_counts,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pnce_pkg::IDX_W-1:0]    i_cell_index,
    output logic                          o_push,
    output pnce_pkg::t_entry              o_entry,
    input  logic                          i_full
);

    localparam int DIV_CYCLES = pnce_pkg::IDX_W / 2;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_S0   = 6'b000010,
        S_TOT  = 6'b000100,
        S_DIV  = 6'b001000,
        S_MUL  = 6'b010000,
        S_PUSH = 6'b100000
    } t_front_state;

    t_front_state                    r_state, n_state;
    logic [pnce_pkg::IDX_W-1:0]      r_self;
    logic [pnce_pkg::S0_W-1:0]       r_s0;
    logic [pnce_pkg::TOT_W-1:0]      r_total;
    logic                            r_err;
    logic [pnce_pkg::IDX_W-1:0]      r_dq, n_dq;
    logic [pnce_pkg::COORD_W-1:0]    r_rem;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_pass;
    logic [pnce_pkg::COORD_W-1:0]    r_c0, r_c1, r_c2;
    logic [pnce_pkg::IDX_W-1:0]      r_p0;
    logic [pnce_pkg::P1_W-1:0]       r_p1;

    logic [13:0]                     w_s0_full;
    logic [19:0]                     w_tot_full;
    logic [12:0]                     w_p1_full;
    logic [18:0]                     w_p0_full;
    logic [pnce_pkg::CELL_W-1:0]     w_div;
    logic [6:0]                      w_t1, w_t2;
    logic                            w_ge1, w_ge2;
    logic [pnce_pkg::COORD_W-1:0]    w_rem1, w_rem2;

    assign w_s0_full  = {7'b0, i_counts.n1} * {7'b0, i_counts.n2};
    assign w_tot_full = {13'b0, i_counts.n0} * {7'b0, r_s0};
    assign w_p1_full  = {7'b0, r_c1} * {6'b0, i_counts.n2};
    assign w_p0_full  = {13'b0, r_c0} * {6'b0, r_s0};

    // restoring division, two quotient bits per cycle
    assign w_div  = r_pass ? i_counts.n1 : i_counts.n2;
    assign w_t1   = {r_rem, r_dq[pnce_pkg::IDX_W-1]};
    assign w_ge1  = (w_t1 >= w_div);
    assign w_rem1 = w_ge1 ? pnce_pkg::COORD_W'(w_t1 - w_div) : w_t1[pnce_pkg::COORD_W-1:0];
    assign w_t2   = {w_rem1, r_dq[pnce_pkg::IDX_W-2]};
    assign w_ge2  = (w_t2 >= w_div);
    assign w_rem2 = w_ge2 ? pnce_pkg::COORD_W'(w_t2 - w_div) : w_t2[pnce_pkg::COORD_W-1:0];
    assign n_dq   = {r_dq[pnce_pkg::IDX_W-3:0], w_ge1, w_ge2};

    assign o_in_stall = (r_state != S_IDLE);
    assign o_push     = (r_state == S_PUSH) && !i_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_S0;
                end
            end
            S_S0:   n_state = S_TOT;
            S_TOT: begin
                if ({1'b0, r_self} >= pnce_pkg::TOT_W'(w_tot_full)) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_pass && (r_cnt == CNT_W'(DIV_CYCLES - 1))) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_PUSH;
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_self <= i_cell_index;
            end
            S_S0: begin
                r_s0 <= w_s0_full[pnce_pkg::S0_W-1:0];
            end
            S_TOT: begin
                r_total <= pnce_pkg::TOT_W'(w_tot_full);
                r_err   <= ({1'b0, r_self} >= pnce_pkg::TOT_W'(w_tot_full));
                r_dq    <= r_self;
                r_rem   <= '0;
                r_cnt   <= '0;
                r_pass  <= 1'b0;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_dq  <= n_dq;
                    if (!r_pass) begin
                        // first pass: remainder is the fastest coordinate
                        r_c2   <= w_rem2;
                        r_pass <= 1'b1;
                    end else begin
                        r_c1 <= w_rem2;
                        r_c0 <= n_dq[pnce_pkg::COORD_W-1:0];
                    end
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_rem <= w_rem2;
                    r_dq  <= n_dq;
                end
            end
            S_MUL: begin
                r_p1 <= w_p1_full[pnce_pkg::P1_W-1:0];
                r_p0 <= w_p0_full[pnce_pkg::IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // wrapped per-dimension contributions and the digits of the final neighbor
    logic [2:0]           w_one, w_two;
    pnce_pkg::t_digit     w_m0, w_m1, w_m2;
    logic                 w_max_self;

    always_comb begin
        w_one = {i_counts.n2 == 7'd1, i_counts.n1 == 7'd1, i_counts.n0 == 7'd1};
        w_two = {i_counts.n2 == 7'd2, i_counts.n1 == 7'd2, i_counts.n0 == 7'd2};
        w_m0  = w_one[0] ? pnce_pkg::OFF_MINUS : (w_two[0] ? pnce_pkg::OFF_ZERO : pnce_pkg::OFF_PLUS);
        w_m1  = w_one[1] ? pnce_pkg::OFF_MINUS : (w_two[1] ? pnce_pkg::OFF_ZERO : pnce_pkg::OFF_PLUS);
        w_m2  = w_one[2] ? pnce_pkg::OFF_MINUS : (w_two[2] ? pnce_pkg::OFF_ZERO : pnce_pkg::OFF_PLUS);
        w_max_self = &(w_one | w_two);

        o_entry       = '0;
        o_entry.err   = r_err;
        o_entry.one   = w_one;
        o_entry.two   = w_two;

        o_entry.a2_z  = r_c2;
        o_entry.a2_m  = (r_c2 == '0) ? pnce_pkg::COORD_W'(i_counts.n2 - 7'd1)
                                     : r_c2 - pnce_pkg::COORD_W'(1);
        o_entry.a2_p  = (({1'b0, r_c2} + 7'd1) >= i_counts.n2) ? '0
                                     : r_c2 + pnce_pkg::COORD_W'(1);

        o_entry.a1_z  = r_p1;
        o_entry.a1_m  = (r_c1 == '0) ? pnce_pkg::P1_W'(r_s0 - {6'b0, i_counts.n2})
                                     : pnce_pkg::P1_W'({1'b0, r_p1} - {6'b0, i_counts.n2});
        o_entry.a1_p  = (({1'b0, r_c1} + 7'd1) >= i_counts.n1) ? '0
                                     : pnce_pkg::P1_W'({1'b0, r_p1} + {6'b0, i_counts.n2});

        o_entry.a0_z  = r_p0;
        o_entry.a0_m  = (r_c0 == '0) ? pnce_pkg::IDX_W'(r_total - {6'b0, r_s0})
                                     : pnce_pkg::IDX_W'({1'b0, r_p0} - {6'b0, r_s0});
        o_entry.a0_p  = (({1'b0, r_c0} + 7'd1) >= i_counts.n0) ? '0
                                     : pnce_pkg::IDX_W'({1'b0, r_p0} + {6'b0, r_s0});

        // the highest canonical offset is the last neighbor unless it is the
        // cell itself; then the lowest two-cell dimension drops to minus
        o_entry.last0 = w_m0;
        o_entry.last1 = w_m1;
        o_entry.last2 = w_m2;
        if (w_max_self) begin
            if (w_two[0]) begin
                o_entry.last0 = pnce_pkg::OFF_MINUS;
            end else if (w_two[1]) begin
                o_entry.last1 = pnce_pkg::OFF_MINUS;
            end else if (w_two[2]) begin
                o_entry.last2 = pnce_pkg::OFF_MINUS;
            end
        end
    end

endmodule

// ===== rtl/pnce_queue.sv =====
`timescale 1ns / 1ps

module pnce_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pnce_pkg::t_entry  i_data,
    output logic              o_full,
    output logic              o_valid,
    output pnce_pkg::t_entry  o_data,
    input  logic              i_pop
);

    localparam int PTR_W = (pnce_pkg::Q_DEPTH > 1) ? $clog2(pnce_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(pnce_pkg::Q_DEPTH + 1);

    pnce_pkg::t_entry  r_mem [pnce_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(pnce_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(pnce_pkg::Q_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(pnce_pkg::Q_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/pnce_back.sv =====
`timescale 1ns / 1ps

module pnce_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  pnce_pkg::t_entry              i_q_data,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pnce_pkg::IDX_W-1:0]    o_neighbor_index,
    output logic                          o_last,
    output logic                          o_index_error
);

    logic                          r_active;
    pnce_pkg::t_entry              r_ent;
    pnce_pkg::t_digit              r_o0, r_o1, r_o2;
    pnce_pkg::t_digit              n_o0, n_o1, n_o2;
    logic                          r_out_valid;
    logic [pnce_pkg::IDX_W-1:0]    r_out_idx;
    logic                          r_out_last;
    logic                          r_out_err;

    logic [pnce_pkg::IDX_W-1:0]    w_a0;
    logic [pnce_pkg::P1_W-1:0]     w_a1;
    logic [pnce_pkg::COORD_W-1:0]  w_a2;
    logic [pnce_pkg::IDX_W-1:0]    w_lin;
    logic                          w_canon, w_self, w_emit, w_is_last, w_end;
    logic                          w_adv, w_step, w_done, w_load;

    always_comb begin
        case (r_o0)
            pnce_pkg::OFF_MINUS: w_a0 = r_ent.a0_m;
            pnce_pkg::OFF_ZERO:  w_a0 = r_ent.a0_z;
            default:             w_a0 = r_ent.a0_p;
        endcase
        case (r_o1)
            pnce_pkg::OFF_MINUS: w_a1 = r_ent.a1_m;
            pnce_pkg::OFF_ZERO:  w_a1 = r_ent.a1_z;
            default:             w_a1 = r_ent.a1_p;
        endcase
        case (r_o2)
            pnce_pkg::OFF_MINUS: w_a2 = r_ent.a2_m;
            pnce_pkg::OFF_ZERO:  w_a2 = r_ent.a2_z;
            default:             w_a2 = r_ent.a2_p;
        endcase
    end

    assign w_lin = w_a0 + {6'b0, w_a1} + {12'b0, w_a2};

    // a neighbor is new only if every dimension uses its first offset for
    // that wrapped coordinate, and it is not the cell itself
    assign w_canon = pnce_pkg::f_canon(r_ent.one[0], r_ent.two[0], r_o0)
                   & pnce_pkg::f_canon(r_ent.one[1], r_ent.two[1], r_o1)
                   & pnce_pkg::f_canon(r_ent.one[2], r_ent.two[2], r_o2);
    assign w_self  = (r_ent.one[0] || (r_o0 == pnce_pkg::OFF_ZERO))
                   && (r_ent.one[1] || (r_o1 == pnce_pkg::OFF_ZERO))
                   && (r_ent.one[2] || (r_o2 == pnce_pkg::OFF_ZERO));
    assign w_emit  = w_canon && !w_self;

    assign w_is_last = (r_o0 == r_ent.last0) && (r_o1 == r_ent.last1)
                    && (r_o2 == r_ent.last2);
    assign w_end     = (w_emit && w_is_last)
                    || ((r_o0 == pnce_pkg::OFF_PLUS) && (r_o1 == pnce_pkg::OFF_PLUS)
                        && (r_o2 == pnce_pkg::OFF_PLUS));

    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_step = r_active && w_adv;
    assign w_done = w_step && (r_ent.err || w_end);
    assign w_load = (!r_active || w_done) && i_q_valid;
    assign o_q_pop = w_load;

    // offset counter, dimension 0 fastest
    always_comb begin
        n_o0 = r_o0;
        n_o1 = r_o1;
        n_o2 = r_o2;
        if (r_o0 == pnce_pkg::OFF_PLUS) begin
            n_o0 = pnce_pkg::OFF_MINUS;
            if (r_o1 == pnce_pkg::OFF_PLUS) begin
                n_o1 = pnce_pkg::OFF_MINUS;
                n_o2 = r_o2 + 2'd1;
            end else begin
                n_o1 = r_o1 + 2'd1;
            end
        end else begin
            n_o0 = r_o0 + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_active <= 1'b1;
            end else if (w_done) begin
                r_active <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= w_step && (r_ent.err || w_emit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ent <= i_q_data;
            r_o0  <= pnce_pkg::OFF_MINUS;
            r_o1  <= pnce_pkg::OFF_MINUS;
            r_o2  <= pnce_pkg::OFF_MINUS;
        end else if (w_step) begin
            r_o0 <= n_o0;
            r_o1 <= n_o1;
            r_o2 <= n_o2;
        end
        if (w_adv) begin
            r_out_idx  <= r_ent.err ? '0 : w_lin;
            r_out_last <= r_ent.err || w_is_last;
            r_out_err  <= r_ent.err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_neighbor_index = r_out_idx;
    assign o_last           = r_out_last;
    assign o_index_error    = r_out_err;

endmodule
